// ===== hdl/rcpa_pkg.sv =====
// Shared constants, codes and types of the reference-counted page allocator.
package rcpa_pkg;

   localparam int NUM_PAGES   = 32768;
   localparam int REF_BITS    = 8;
   localparam int PAGE_W      = $clog2(NUM_PAGES);
   localparam int CNT_W       = PAGE_W + 1;
   localparam int CFG_W       = 15;
   localparam int RES_W       = 15;
   localparam int FUNC_W      = 2;
   localparam int REQ_PAGE_W  = 16;
   localparam int STATUS_W    = 3;
   // The queue depth must be a power of two so the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_FREE   = 2'd1,
      FUNC_ADDREF = 2'd2,
      FUNC_COW    = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NO_MEMORY = 3'd1,
      STAT_RANGE     = 3'd2,
      STAT_NOT_ALLOC = 3'd3,
      STAT_SATURATED = 3'd4
   } status_type;

   typedef struct packed {
      func_type             func;
      logic [PAGE_W-1:0]    page;
      logic                 range_err;
   } op_type;

   typedef enum logic [1:0] {
      BS_IDLE   = 2'd0,
      BS_EXEC   = 2'd1,
      BS_SETNEW = 2'd2
   } back_state_type;

endpackage

// ===== hdl/rcpa_front.sv =====
// Request front end: range classification and a short operation queue.
module rcpa_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rcpa_pkg::CFG_W-1:0]          first_usable,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rcpa_pkg::FUNC_W-1:0]         req_func,
   input  logic [rcpa_pkg::REQ_PAGE_W-1:0]     req_page_number,
   output logic                                op_valid,
   input  logic                                op_ready,
   output rcpa_pkg::op_type                    op
);

   rcpa_pkg::op_type                   queue_ff [rcpa_pkg::QUEUE_DEPTH];
   logic [rcpa_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [rcpa_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [rcpa_pkg::QCNT_W-1:0]        count_ff, count_in;
   rcpa_pkg::op_type                   entry;
   logic                               push;
   logic                               pop;

   // A page outside [first_usable, NUM_PAGES) is flagged here; alloc ignores it.
   always_comb begin
      entry.func      = rcpa_pkg::func_type'(req_func);
      entry.page      = req_page_number[rcpa_pkg::PAGE_W-1:0];
      entry.range_err = (32'(req_page_number) < 32'(first_usable)) ||
                        (32'(req_page_number) >= rcpa_pkg::NUM_PAGES);
   end

   // No beat is taken while reset is held.
   assign req_ready = !reset && (count_ff != rcpa_pkg::QCNT_W'(rcpa_pkg::QUEUE_DEPTH));
   assign op_valid  = (count_ff != '0);
   assign op        = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rcpa_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + rcpa_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rcpa_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rcpa_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rcpa_pkg::QCNT_W'(rcpa_pkg::QUEUE_DEPTH))
      else $error("operation queue holds more entries than its depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + rcpa_pkg::QCNT_W'(1)))
      else $error("queue occupancy did not follow a push");

endmodule

// ===== hdl/rcpa_back.sv =====
// Back end: count and free-stack memories, allocation sequencer, result register.
module rcpa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rcpa_pkg::CFG_W-1:0]          first_usable,
   input  logic                                op_valid,
   output logic                                op_ready,
   input  rcpa_pkg::op_type                    op,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rcpa_pkg::RES_W-1:0]          rsp_result_page,
   output logic [rcpa_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_page_released,
   output logic                                rsp_copy_needed
);

   logic [rcpa_pkg::REF_BITS-1:0]  count_mem [rcpa_pkg::NUM_PAGES];
   logic [rcpa_pkg::PAGE_W-1:0]    stack_mem [rcpa_pkg::NUM_PAGES];

   rcpa_pkg::back_state_type       state_ff, state_in;
   rcpa_pkg::op_type               op_ff;
   logic [rcpa_pkg::REF_BITS-1:0]  count_rd_ff;
   logic [rcpa_pkg::PAGE_W-1:0]    stack_rd_ff;
   logic [rcpa_pkg::CNT_W-1:0]     stack_count_ff, stack_count_in;
   logic [rcpa_pkg::CNT_W-1:0]     fresh_top_ff, fresh_top_in;
   logic [rcpa_pkg::PAGE_W-1:0]    new_page_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rcpa_pkg::RES_W-1:0]     rsp_page_ff;
   rcpa_pkg::status_type           rsp_status_ff;
   logic                           rsp_released_ff;
   logic                           rsp_copy_ff;

   logic                           pop_fire;
   logic                           exec_fire;
   logic [rcpa_pkg::CNT_W-1:0]     stack_rd_idx;
   logic [rcpa_pkg::CNT_W-1:0]     fresh_dec;
   logic [rcpa_pkg::REF_BITS-1:0]  cnt_eff;
   logic                           can_pop;
   logic                           can_fresh;
   logic                           take_ok;
   logic [rcpa_pkg::PAGE_W-1:0]    take_page;

   logic [rcpa_pkg::PAGE_W-1:0]    res_page;
   rcpa_pkg::status_type           status;
   logic                           released;
   logic                           copy;
   logic                           do_take;
   logic                           do_push;
   logic                           cnt_we;
   logic [rcpa_pkg::PAGE_W-1:0]    cnt_wa;
   logic [rcpa_pkg::REF_BITS-1:0]  cnt_wd;
   logic                           mem_we;
   logic [rcpa_pkg::PAGE_W-1:0]    mem_wa;
   logic [rcpa_pkg::REF_BITS-1:0]  mem_wd;

   assign pop_fire  = (state_ff == rcpa_pkg::BS_IDLE) && op_valid;
   assign exec_fire = (state_ff == rcpa_pkg::BS_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign op_ready  = (state_ff == rcpa_pkg::BS_IDLE);

   assign stack_rd_idx = stack_count_ff - rcpa_pkg::CNT_W'(1);
   assign fresh_dec    = fresh_top_ff - rcpa_pkg::CNT_W'(1);

   // Pages below the fresh pointer were never handed out, so their count is
   // zero no matter what the count memory holds there.
   assign cnt_eff   = (rcpa_pkg::CNT_W'(op_ff.page) >= fresh_top_ff) ? count_rd_ff : '0;
   assign can_pop   = (stack_count_ff != '0);
   assign can_fresh = (32'(fresh_top_ff) > 32'(first_usable));
   assign take_ok   = can_pop || can_fresh;
   assign take_page = can_pop ? stack_rd_ff : fresh_dec[rcpa_pkg::PAGE_W-1:0];

   // Operation decode for the execute step.
   always_comb begin
      res_page = '0;
      status   = rcpa_pkg::STAT_OK;
      released = 1'b0;
      copy     = 1'b0;
      do_take  = 1'b0;
      do_push  = 1'b0;
      cnt_we   = 1'b0;
      cnt_wa   = op_ff.page;
      cnt_wd   = '0;
      if (op_ff.func == rcpa_pkg::FUNC_ALLOC) begin
         if (take_ok) begin
            res_page = rcpa_pkg::RES_W'(take_page);
            do_take  = 1'b1;
            cnt_we   = 1'b1;
            cnt_wa   = take_page;
            cnt_wd   = rcpa_pkg::REF_BITS'(1);
         end else begin
            status = rcpa_pkg::STAT_NO_MEMORY;
         end
      end else if (op_ff.range_err) begin
         status = rcpa_pkg::STAT_RANGE;
      end else if (cnt_eff == '0) begin
         status = rcpa_pkg::STAT_NOT_ALLOC;
      end else begin
         case (op_ff.func)
            rcpa_pkg::FUNC_FREE: begin
               cnt_we = 1'b1;
               cnt_wd = cnt_eff - rcpa_pkg::REF_BITS'(1);
               if (cnt_eff == rcpa_pkg::REF_BITS'(1)) begin
                  do_push  = 1'b1;
                  released = 1'b1;
               end
            end
            rcpa_pkg::FUNC_ADDREF: begin
               if (cnt_eff == rcpa_pkg::REF_MAX) begin
                  status = rcpa_pkg::STAT_SATURATED;
               end else begin
                  cnt_we = 1'b1;
                  cnt_wd = cnt_eff + rcpa_pkg::REF_BITS'(1);
               end
            end
            rcpa_pkg::FUNC_COW: begin
               if (cnt_eff <= rcpa_pkg::REF_BITS'(1)) begin
                  res_page = rcpa_pkg::RES_W'(op_ff.page);
               end else if (take_ok) begin
                  // The old count is written now, the new page's count next cycle.
                  res_page = rcpa_pkg::RES_W'(take_page);
                  copy     = 1'b1;
                  do_take  = 1'b1;
                  cnt_we   = 1'b1;
                  cnt_wd   = cnt_eff - rcpa_pkg::REF_BITS'(1);
               end else begin
                  status = rcpa_pkg::STAT_NO_MEMORY;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcpa_pkg::BS_IDLE: begin
            if (op_valid) begin
               state_in = rcpa_pkg::BS_EXEC;
            end
         end
         rcpa_pkg::BS_EXEC: begin
            if (exec_fire) begin
               state_in = copy ? rcpa_pkg::BS_SETNEW : rcpa_pkg::BS_IDLE;
            end
         end
         rcpa_pkg::BS_SETNEW: begin
            state_in = rcpa_pkg::BS_IDLE;
         end
         default: begin
            state_in = rcpa_pkg::BS_IDLE;
         end
      endcase
   end

   // State outputs: memory write port and counter updates.
   always_comb begin
      mem_we         = 1'b0;
      mem_wa         = cnt_wa;
      mem_wd         = cnt_wd;
      stack_count_in = stack_count_ff;
      fresh_top_in   = fresh_top_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         rcpa_pkg::BS_EXEC: begin
            if (exec_fire) begin
               mem_we       = cnt_we;
               rsp_valid_in = 1'b1;
               if (do_take) begin
                  if (can_pop) begin
                     stack_count_in = stack_rd_idx;
                  end else begin
                     fresh_top_in = fresh_dec;
                  end
               end
               if (do_push && (stack_count_ff < rcpa_pkg::CNT_W'(rcpa_pkg::NUM_PAGES))) begin
                  stack_count_in = stack_count_ff + rcpa_pkg::CNT_W'(1);
               end
            end
         end
         rcpa_pkg::BS_SETNEW: begin
            mem_we = 1'b1;
            mem_wa = new_page_ff;
            mem_wd = rcpa_pkg::REF_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rcpa_pkg::BS_IDLE;
         stack_count_ff <= '0;
         fresh_top_ff   <= rcpa_pkg::CNT_W'(rcpa_pkg::NUM_PAGES);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         stack_count_ff <= stack_count_in;
         fresh_top_ff   <= fresh_top_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         op_ff <= op;
      end
      if (exec_fire) begin
         new_page_ff     <= take_page;
         rsp_page_ff     <= res_page;
         rsp_status_ff   <= status;
         rsp_released_ff <= released;
         rsp_copy_ff     <= copy;
      end
   end

   // Reference count memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_wa] <= mem_wd;
      end
      if (pop_fire) begin
         count_rd_ff <= count_mem[op.page];
      end
   end

   // Free stack memory: the top entry is read ahead while the item is fetched.
   always_ff @(posedge clock) begin
      if (exec_fire && do_push && (stack_count_ff < rcpa_pkg::CNT_W'(rcpa_pkg::NUM_PAGES))) begin
         stack_mem[stack_count_ff[rcpa_pkg::PAGE_W-1:0]] <= op_ff.page;
      end
      if (pop_fire) begin
         stack_rd_ff <= stack_mem[stack_rd_idx[rcpa_pkg::PAGE_W-1:0]];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_page   = rsp_page_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_page_released = rsp_released_ff;
   assign rsp_copy_needed   = rsp_copy_ff;

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stack_count_ff <= rcpa_pkg::CNT_W'(rcpa_pkg::NUM_PAGES))
      else $error("free stack count exceeds the number of pages");

   a_fresh_down: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (fresh_top_ff <= $past(fresh_top_ff)))
      else $error("fresh page pointer moved upward");

   a_push_xor_take: assert property (@(posedge clock) disable iff (reset)
      exec_fire |-> !(do_push && do_take))
      else $error("one operation both pushed and took a page");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_released_ff && rsp_copy_ff))
      else $error("result flags both release and copy");

endmodule

// ===== hdl/refcounted_page_allocator_top.sv =====
// Top level of the reference-counted page allocator.
//
// Requests arrive on the req_ channel (func, page_number) with valid/ready;
// one result beat per request leaves on the rsp_ channel in request order.
// The csr_ port writes first_usable_page with no handshake; it is to be written
// only while the block is idle, and the block itself does not enforce this.
// A front end classifies each request and holds it in a two-entry queue;
// the back end fetches one entry and reads the count memory and the top of the
// free stack in that cycle, then executes once the result register is free,
// loading the result register. The back end takes one request at a time,
// held back by the read-modify-write of the count memory and its registered
// read; a copy-on-write resolve that hands out a new page adds a step that
// writes the new page's count through the memory's one write port.
// Reset clears the queue, the stack depth and the result valid, and sets
// the fresh-page pointer to the page count; no memory sweep is needed, so
// the block takes requests as soon as reset falls.
// While rsp_ready is low the result beat holds; the back end stops at its
// execute step and the queue fills, after which req_ready drops.
module refcounted_page_allocator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rcpa_pkg::FUNC_W-1:0]         req_func,
   input  logic [rcpa_pkg::REQ_PAGE_W-1:0]     req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rcpa_pkg::RES_W-1:0]          rsp_result_page,
   output logic [rcpa_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_page_released,
   output logic                                rsp_copy_needed,
   input  logic                                csr_wr_en,
   input  logic [rcpa_pkg::CFG_W-1:0]          csr_wr_data
);

   logic [rcpa_pkg::CFG_W-1:0]  first_usable_ff, first_usable_in;
   logic                        op_valid;
   logic                        op_ready;
   rcpa_pkg::op_type            op;

   assign first_usable_in = csr_wr_en ? csr_wr_data : first_usable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_usable_ff <= '0;
      end else begin
         first_usable_ff <= first_usable_in;
      end
   end

   rcpa_front u_front (
      .clock           (clock),
      .reset           (reset),
      .first_usable    (first_usable_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_page_number (req_page_number),
      .op_valid        (op_valid),
      .op_ready        (op_ready),
      .op              (op)
   );

   rcpa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .first_usable      (first_usable_ff),
      .op_valid          (op_valid),
      .op_ready          (op_ready),
      .op                (op),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_page   (rsp_result_page),
      .rsp_status        (rsp_status),
      .rsp_page_released (rsp_page_released),
      .rsp_copy_needed   (rsp_copy_needed)
   );

endmodule

// ===== verif/rcpa_result_check.sv =====
// Result checker for the page allocator: predicts each result beat and compares it.
`timescale 1ns / 1ps

module rcpa_result_check
   import rcpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [REQ_PAGE_W-1:0] req_page_number,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [RES_W-1:0]      rsp_result_page,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic                  rsp_page_released,
   input  logic                  rsp_copy_needed,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,
   output int                    mismatches,
   output int                    pending,
   output int                    checked,
   output int                    copies,
   output int                    releases,
   output logic [4:0]            status_seen
);

   typedef struct packed {
      logic [RES_W-1:0] page;
      status_type       status;
      logic             released;
      logic             copy;
   } outcome_type;

   // Shadow of the allocator state.
   logic [REF_BITS-1:0] page_refs [NUM_PAGES];
   logic [PAGE_W-1:0]   free_pages [NUM_PAGES];
   int                  free_depth;
   int                  fresh_next;
   logic [CFG_W-1:0]    low_page;

   outcome_type expected_results [$];

   // Pops the free stack first, then falls back to the descending fresh pointer.
   function automatic logic grab_page(output logic [PAGE_W-1:0] pg);
      pg = '0;
      if (free_depth > 0) begin
         free_depth--;
         pg = free_pages[free_depth];
      end else if (fresh_next > int'(low_page)) begin
         fresh_next--;
         pg = PAGE_W'(fresh_next);
      end else begin
         return 1'b0;
      end
      page_refs[pg] = REF_BITS'(1);
      return 1'b1;
   endfunction

   function automatic outcome_type predict_outcome(input func_type f,
                                                   input logic [REQ_PAGE_W-1:0] pn);
      outcome_type       o;
      logic [PAGE_W-1:0] pg;
      logic [PAGE_W-1:0] fresh;
      o = '0;
      pg = pn[PAGE_W-1:0];
      if (f == FUNC_ALLOC) begin
         if (grab_page(fresh)) o.page = fresh;
         else o.status = STAT_NO_MEMORY;
      end else if (int'(pn) < int'(low_page) || int'(pn) >= NUM_PAGES) begin
         o.status = STAT_RANGE;
      end else if (page_refs[pg] == '0) begin
         o.status = STAT_NOT_ALLOC;
      end else begin
         case (f)
            FUNC_FREE: begin
               page_refs[pg] = page_refs[pg] - 1'b1;
               if (page_refs[pg] == '0) begin
                  if (free_depth < NUM_PAGES) begin
                     free_pages[free_depth] = pg;
                     free_depth++;
                  end
                  o.released = 1'b1;
               end
            end
            FUNC_ADDREF: begin
               if (page_refs[pg] == REF_MAX) o.status = STAT_SATURATED;
               else page_refs[pg] = page_refs[pg] + 1'b1;
            end
            default: begin
               // Copy-on-write resolve: a sole owner keeps its page.
               if (page_refs[pg] <= REF_BITS'(1)) begin
                  o.page = pg;
               end else if (grab_page(fresh)) begin
                  page_refs[pg] = page_refs[pg] - 1'b1;
                  o.page = fresh;
                  o.copy = 1'b1;
               end else begin
                  o.status = STAT_NO_MEMORY;
               end
            end
         endcase
      end
      return o;
   endfunction

   task automatic report(input string field, input int got, input int want);
      mismatches++;
      $display("check: result beat %0d: %s is %0h, expected %0h", checked, field, got, want);
   endtask

   always @(posedge clock) begin : watch
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++) page_refs[i] = '0;
         free_depth = 0;
         fresh_next = NUM_PAGES;
         low_page = '0;
         expected_results.delete();
         mismatches = 0;
         checked = 0;
         copies = 0;
         releases = 0;
         status_seen = '0;
      end else begin
         if (csr_wr_en) low_page = csr_wr_data;
         // Compare before predicting, so a stray result never meets a fresh expectation.
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (rsp_copy_needed) copies++;
            if (rsp_page_released) releases++;
            if (rsp_status <= STAT_SATURATED) status_seen[rsp_status] = 1'b1;
            if (expected_results.size() == 0) begin
               report("unrequested beat", rsp_status, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_page !== want.page)
                  report("result_page", rsp_result_page, want.page);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
               if (rsp_page_released !== want.released)
                  report("page_released", rsp_page_released, want.released);
               if (rsp_copy_needed !== want.copy)
                  report("copy_needed", rsp_copy_needed, want.copy);
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_outcome(func_type'(req_func), req_page_number));
      end
      pending = expected_results.size();
   end

endmodule

// ===== verif/testbench.sv =====
// Stimulus, handshake pacing and verdict for the reference-counted page allocator.
`timescale 1ns / 1ps

module testbench;
   import rcpa_pkg::*;

   localparam int IDLE_PCT      = 26;
   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 170;

   typedef struct packed {
      func_type              func;
      logic [REQ_PAGE_W-1:0] page;
   } sent_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func = FUNC_ALLOC;
   logic [REQ_PAGE_W-1:0] req_page_number = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RES_W-1:0]      rsp_result_page;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_page_released;
   logic                  rsp_copy_needed;
   logic                  csr_wr_en = 1'b0;
   logic [CFG_W-1:0]      csr_wr_data = '0;

   int         mismatches;
   int         pending;
   int         checked;
   int         copies;
   int         releases;
   logic [4:0] status_seen;

   // Pacing controls shared with the result-side process.
   bit               steady = 1'b0;
   int               holds_asked = 0;
   int               holds_served = 0;
   int               hold_left = 0;
   int               quiet_cycles = 0;
   int               requests = 0;
   int               settings = 0;
   logic [CFG_W-1:0] low_page_now = '0;

   // Pages currently handed out, kept only to aim requests at live pages.
   sent_type          in_flight [$];
   logic              is_held [NUM_PAGES];
   logic [PAGE_W-1:0] held_pages [$];

   always #1 clock = ~clock;

   refcounted_page_allocator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_page   (rsp_result_page),
      .rsp_status        (rsp_status),
      .rsp_page_released (rsp_page_released),
      .rsp_copy_needed   (rsp_copy_needed),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   rcpa_result_check result_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_page   (rsp_result_page),
      .rsp_status        (rsp_status),
      .rsp_page_released (rsp_page_released),
      .rsp_copy_needed   (rsp_copy_needed),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .mismatches        (mismatches),
      .pending           (pending),
      .checked           (checked),
      .copies            (copies),
      .releases          (releases),
      .status_seen       (status_seen)
   );

   // Result side: random back-pressure, plus long hold-offs on request.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served < holds_asked) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : track_pages
      sent_type done;
      logic [PAGE_W-1:0] gone;
      if (reset) begin
         for (int i = 0; i < NUM_PAGES; i++) is_held[i] = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready && in_flight.size() != 0) begin
            done = in_flight.pop_front();
            if (rsp_status == STAT_OK) begin
               if ((done.func == FUNC_ALLOC || rsp_copy_needed) && !is_held[rsp_result_page]) begin
                  is_held[rsp_result_page] = 1'b1;
                  held_pages.push_back(rsp_result_page);
               end
               if (rsp_page_released) begin
                  gone = done.page[PAGE_W-1:0];
                  is_held[gone] = 1'b0;
                  for (int i = 0; i < held_pages.size(); i++) begin
                     if (held_pages[i] == gone) begin
                        held_pages.delete(i);
                        break;
                     end
                  end
               end
            end
         end
         if (req_valid && req_ready) in_flight.push_back({func_type'(req_func), req_page_number});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: no beat on either channel for %0d cycles", STALL_LIMIT);
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_request(input func_type f, input logic [REQ_PAGE_W-1:0] pn);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_page_number <= pn;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests++;
      @(negedge clock);
   endtask

   task automatic settle_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_low_page(input logic [CFG_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      low_page_now = v;
      settings++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly live pages, some near the top of memory, a few anywhere in the field.
   function automatic logic [REQ_PAGE_W-1:0] pick_page();
      int roll;
      int base;
      roll = $urandom_range(0, 99);
      base = (int'(low_page_now) > NUM_PAGES - 64) ? int'(low_page_now) : NUM_PAGES - 64;
      if (roll < 60 && held_pages.size() != 0)
         return REQ_PAGE_W'(held_pages[$urandom_range(0, held_pages.size() - 1)]);
      if (roll < 85) return REQ_PAGE_W'($urandom_range(NUM_PAGES - 1, base));
      return REQ_PAGE_W'($urandom_range(0, 65535));
   endfunction

   task automatic random_phase(input logic [CFG_W-1:0] low, input bit calm, input bit with_hold);
      int roll;
      settle_idle();
      set_low_page(low);
      steady = calm;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (with_hold && n == PHASE_ITEMS / 2) holds_asked++;
         roll = $urandom_range(0, 99);
         if (roll < 30) send_request(FUNC_ALLOC, REQ_PAGE_W'($urandom_range(0, 65535)));
         else if (roll < 55) send_request(FUNC_FREE, pick_page());
         else if (roll < 80) send_request(FUNC_ADDREF, pick_page());
         else send_request(FUNC_COW, pick_page());
      end
      steady = 1'b0;
   endtask

   // Drives one live page to a saturated count and then back down past zero.
   task automatic saturate_page();
      logic [REQ_PAGE_W-1:0] pg;
      settle_idle();
      set_low_page('0);
      send_request(FUNC_ALLOC, '0);
      settle_idle();
      pg = REQ_PAGE_W'(held_pages[$urandom_range(0, held_pages.size() - 1)]);
      repeat (int'(REF_MAX) + 1) send_request(FUNC_ADDREF, pg);
      send_request(FUNC_COW, pg);
      repeat (int'(REF_MAX) + 1) send_request(FUNC_FREE, pg);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single usable page: exhaustion, sharing without a spare page, error codes.
      set_low_page(CFG_W'(NUM_PAGES - 1));
      send_request(FUNC_ALLOC, '0);
      send_request(FUNC_ALLOC, '1);
      send_request(FUNC_COW, 16'd32767);
      send_request(FUNC_ADDREF, 16'd32767);
      send_request(FUNC_COW, 16'd32767);
      send_request(FUNC_FREE, 16'd32767);
      send_request(FUNC_FREE, 16'd32767);
      send_request(FUNC_FREE, 16'd32767);
      send_request(FUNC_ADDREF, 16'd32767);
      send_request(FUNC_COW, 16'd32767);
      send_request(FUNC_FREE, 16'd32766);
      send_request(FUNC_ADDREF, 16'hFFFF);
      send_request(FUNC_COW, 16'h8000);
      send_request(FUNC_ALLOC, 16'h5555);

      // Whole memory usable: fresh pages, a real copy, frees of page zero.
      settle_idle();
      set_low_page('0);
      send_request(FUNC_ALLOC, 16'hAAAA);
      send_request(FUNC_ADDREF, 16'd32766);
      send_request(FUNC_COW, 16'd32766);
      send_request(FUNC_FREE, 16'd0);
      send_request(FUNC_ADDREF, 16'd0);
      send_request(FUNC_FREE, 16'd32765);
      send_request(FUNC_COW, 16'd32766);
      send_request(FUNC_ALLOC, '0);

      random_phase('0, 1'b1, 1'b1);
      random_phase(CFG_W'(NUM_PAGES - 1), 1'b0, 1'b0);
      random_phase(CFG_W'($urandom_range(NUM_PAGES - 64, NUM_PAGES - 1)), 1'b0, 1'b0);
      saturate_page();
      random_phase(CFG_W'($urandom_range(0, NUM_PAGES - 1)), 1'b0, 1'b0);
      random_phase('0, 1'b0, 1'b1);
      random_phase(CFG_W'(NUM_PAGES - 1), 1'b0, 1'b0);

      settle_idle();
      $display("run: %0d requests under %0d low-page settings, with one count pumped to saturation",
               requests, settings);
      $display("run: %0d results checked, %0d copies, %0d releases, status codes seen %b",
               checked, copies, releases, status_seen);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
